// ===== rtl/ugli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugli_pkg: shared types and codes of the grid lookup interpolator
// Holds mode and status codes, sequencer states and the arithmetic unit request.
// ----------------------------------------------------------------------------
package ugli_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int FRAC_BITS_DEF   = 16;

    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_APPEND  = 2'd1;
    localparam logic [1:0] MODE_NEAREST = 2'd2;
    localparam logic [1:0] MODE_LINEAR  = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_RANGE   = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_NOT_ASC = 2'd3;

    localparam logic CFG_STEP  = 1'b0;
    localparam logic CFG_RECIP = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_A_RD,
        ST_A_DIV,
        ST_A_MUL,
        ST_A_LOOP,
        ST_Q_BIN,
        ST_Q_RD1,
        ST_Q_RD2,
        ST_Q_RD3,
        ST_Q_X1,
        ST_Q_W,
        ST_Q_Y
    } state_t;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } mdu_op_t;

    typedef struct packed {
        logic    start;
        mdu_op_t op;
    } mdu_req_t;

endpackage

// ===== rtl/ugli_mdu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugli_mdu: serial multiply / divide unit
// Shift-add multiply of a signed by an unsigned operand, one bit per cycle, and
// restoring division truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ugli_mdu #(
    parameter int A_W = 50,
    parameter int B_W = 33
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ugli_pkg::mdu_req_t       req,
    input  logic signed [A_W-1:0]    a,
    input  logic        [B_W-1:0]    b,
    output logic                     done,
    output logic signed [A_W+B_W-1:0] result
);

    localparam int P_W = A_W + B_W;
    localparam int C_W = $clog2(A_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    ugli_pkg::mdu_op_t op_reg, op_next;
    logic [C_W-1:0]    cnt_reg, cnt_next;
    logic [P_W-1:0]    acc_reg, acc_next;
    logic [P_W-1:0]    mcand_reg, mcand_next;
    logic [B_W-1:0]    mplier_reg, mplier_next;
    logic [A_W-1:0]    num_reg, num_next;
    logic [B_W-1:0]    rem_reg, rem_next;
    logic [A_W-1:0]    quo_reg, quo_next;
    logic              neg_reg, neg_next;

    logic [B_W:0]      rem_sh;
    logic              fits;
    logic              last;
    logic [A_W-1:0]    quo_signed;

    assign rem_sh = {rem_reg, num_reg[A_W-1]};
    assign fits   = rem_sh >= {1'b0, mplier_reg};
    assign last   = (op_reg == ugli_pkg::OP_MUL) ? (cnt_reg == C_W'(B_W - 1))
                                                 : (cnt_reg == C_W'(A_W - 1));

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        neg_next    = neg_reg;
        if (req.start)
        begin
            busy_next   = 1'b1;
            op_next     = req.op;
            cnt_next    = '0;
            acc_next    = '0;
            mcand_next  = P_W'(a);
            mplier_next = b;
            neg_next    = a[A_W-1];
            num_next    = a[A_W-1] ? A_W'(-a) : a;
            rem_next    = '0;
            quo_next    = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (op_reg == ugli_pkg::OP_MUL)
            begin
                acc_next    = (acc_reg << 1) + (mplier_reg[B_W-1] ? mcand_reg : '0);
                mplier_next = mplier_reg << 1;
            end
            else
            begin
                rem_next = fits ? B_W'(rem_sh - {1'b0, mplier_reg}) : rem_sh[B_W-1:0];
                quo_next = {quo_reg[A_W-2:0], fits};
                num_next = num_reg << 1;
            end
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        neg_reg    <= neg_next;
    end

    assign quo_signed = neg_reg ? A_W'(-quo_reg) : quo_reg;
    assign done       = done_reg;
    assign result     = (op_reg == ugli_pkg::OP_MUL) ? $signed(acc_reg)
                                                     : P_W'($signed(quo_signed));

endmodule

// ===== rtl/uniform_grid_lut_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_grid_lut_interpolator: uniform-grid table builder and interpolator
// Builds a grid table from ascending raw points and answers nearest-bin and
// linear queries in signed fixed point, on one serial multiply/divide unit.
// ----------------------------------------------------------------------------
// Usage:
//   Write grid_step (index 0) and step_reciprocal (index 1) through cfg_we,
//   cfg_index and cfg_data while the block is idle. Issue a command by raising
//   start with mode, abscissa and ordinate; the beat is taken when start is
//   high and busy is low. busy stays high until the result beat.
//   Each command answers with one result beat: done is high for one cycle with
//   value, status and entries_used. The receiver cannot stall the block.
// Work per command, from the accepting edge to the done cycle:
//   clear, rejected or skipped point, first point or out-of-range query: no use of the
//   serial multiply/divide unit.
//   append: one divide and one multiply on the unit, then a loop that writes
//   each new grid entry.
//   nearest query: one multiply, one read; linear: four multiplies, two reads.
// Throughput: one command at a time; the next beat can be taken at the edge
// that ends the done cycle.
// Reset clears the entry count, the origin and grid-x registers and both grid
// registers; the grid memory itself is not cleared, as only written entries
// are ever read.
// ----------------------------------------------------------------------------
module uniform_grid_lut_interpolator #(
    parameter int TABLE_DEPTH = ugli_pkg::TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = ugli_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic signed [31:0] abscissa,
    input  logic signed [31:0] ordinate,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic signed [31:0] value,
    output logic [1:0]         status,
    output logic [8:0]         entries_used
);

    localparam int A_W   = 34 + FRAC_BITS;
    localparam int B_W   = 33;
    localparam int P_W   = A_W + B_W;
    localparam int SAT_W = P_W + 1;
    localparam int E_W   = 35;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int W_W   = FRAC_BITS + 5;

    function automatic logic [31:0] sat32(input logic [SAT_W-1:0] s);
        logic hi_same;
        hi_same = (&s[SAT_W-1:31]) | ~(|s[SAT_W-1:31]);
        if (hi_same)
            sat32 = s[31:0];
        else
            sat32 = s[SAT_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

    ugli_pkg::state_t state_reg, state_next;

    logic [1:0]         mode_reg;
    logic signed [31:0] x_reg, y_reg;
    logic [31:0]        step_reg, recip_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [31:0] origin_reg, origin_next;
    logic signed [31:0] lgx_reg, lgx_next;
    logic signed [31:0] lrx_reg, lrx_next;
    logic signed [31:0] y0_reg, y0_next;
    logic signed [E_W-1:0] e_reg, e_next;
    logic signed [P_W-1:0] acc_reg, acc_next;
    logic signed [P_W-1:0] inc_reg, inc_next;
    logic [IDX_W-1:0]   bin_reg, bin_next;
    logic signed [31:0] y1_reg, y1_next;
    logic signed [31:0] y2_reg, y2_next;
    logic               neg_reg, neg_next;
    logic [31:0]        value_reg, value_next;
    logic [1:0]         status_reg, status_next;
    logic               done_reg, done_next;

    // grid memory, one write and one registered read port
    logic signed [31:0] grid_mem [TABLE_DEPTH];
    logic signed [31:0] rdata_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   waddr, raddr;
    logic [31:0]        wdata;

    ugli_pkg::mdu_req_t    mdu_req;
    logic signed [A_W-1:0] mdu_a;
    logic [B_W-1:0]        mdu_b;
    logic                  mdu_done;
    logic signed [P_W-1:0] mdu_p;

    // shared conditions of the sequencer
    logic               first_pt, not_asc, app_skip, q_oor;
    logic signed [32:0] den;
    logic               den_bad;
    logic               loop_go, loop_full;
    logic [31:0]        off;
    logic [P_W-1:0]     bin_big;
    logic [CNT_W-1:0]   bin_clamp, bin_fin;
    logic signed [P_W:0] dx;
    logic [P_W:0]       dx_mag;
    logic [30:0]        mag;
    logic [P_W-1:0]     w_big;
    logic [W_W-1:0]     w_mag;
    logic signed [33:0] dy;

    assign first_pt  = (cnt_reg == '0);
    assign not_asc   = (x_reg <= lrx_reg);
    assign app_skip  = (step_reg == '0) || (cnt_reg > CNT_W'(TABLE_DEPTH));
    assign q_oor     = (step_reg == '0) || (cnt_reg < CNT_W'(2))
                       || (cnt_reg > CNT_W'(TABLE_DEPTH))
                       || (x_reg < origin_reg) || (x_reg > lgx_reg);
    assign den       = 33'(x_reg) - 33'(lgx_reg);
    assign den_bad   = den[32] || (den == '0);
    assign loop_go   = (e_reg < E_W'(x_reg));
    assign loop_full = (cnt_reg >= CNT_W'(TABLE_DEPTH));
    assign off       = 32'(x_reg - origin_reg);

    // bin index from the offset product, clamped to the last entry (one below it for linear)
    assign bin_big   = P_W'(mdu_p) >> (2 * FRAC_BITS);
    assign bin_clamp = (bin_big >= P_W'(cnt_reg)) ? CNT_W'(cnt_reg - 1'b1)
                                                   : CNT_W'(bin_big);
    assign bin_fin   = ((mode_reg == ugli_pkg::MODE_LINEAR) &&
                        (bin_clamp == CNT_W'(cnt_reg - 1'b1)))
                       ? CNT_W'(bin_clamp - 1'b1) : bin_clamp;

    // offset from the lower bin, magnitude capped at the largest positive word
    assign dx     = (P_W + 1)'(x_reg) - (P_W + 1)'(origin_reg) - (P_W + 1)'(mdu_p);
    assign dx_mag = dx[P_W] ? (P_W + 1)'(-dx) : dx;
    assign mag    = (dx_mag > (P_W + 1)'(32'h7fff_ffff)) ? 31'h7fff_ffff : dx_mag[30:0];

    // weight, capped at sixteen steps
    assign w_big  = P_W'(mdu_p) >> FRAC_BITS;
    assign w_mag  = (w_big > (P_W'(1) << (FRAC_BITS + 4))) ? W_W'(1) << (FRAC_BITS + 4)
                                                           : w_big[W_W-1:0];
    assign dy     = 34'(y2_reg) - 34'(y1_reg);

    ugli_mdu #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_mdu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mdu_req),
        .a      (mdu_a),
        .b      (mdu_b),
        .done   (mdu_done),
        .result (mdu_p)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ugli_pkg::ST_IDLE:
                if (start)
                    state_next = ugli_pkg::ST_DECODE;
            ugli_pkg::ST_DECODE:
                case (mode_reg)
                    ugli_pkg::MODE_CLEAR:
                        state_next = ugli_pkg::ST_IDLE;
                    ugli_pkg::MODE_APPEND:
                        state_next = (first_pt || not_asc || app_skip) ? ugli_pkg::ST_IDLE
                                                                       : ugli_pkg::ST_A_RD;
                    default:
                        state_next = q_oor ? ugli_pkg::ST_IDLE : ugli_pkg::ST_Q_BIN;
                endcase
            ugli_pkg::ST_A_RD:
                state_next = den_bad ? ugli_pkg::ST_IDLE : ugli_pkg::ST_A_DIV;
            ugli_pkg::ST_A_DIV:
                if (mdu_done)
                    state_next = ugli_pkg::ST_A_MUL;
            ugli_pkg::ST_A_MUL:
                if (mdu_done)
                    state_next = ugli_pkg::ST_A_LOOP;
            ugli_pkg::ST_A_LOOP:
                if (!loop_go || loop_full)
                    state_next = ugli_pkg::ST_IDLE;
            ugli_pkg::ST_Q_BIN:
                if (mdu_done)
                    state_next = ugli_pkg::ST_Q_RD1;
            ugli_pkg::ST_Q_RD1:
                state_next = ugli_pkg::ST_Q_RD2;
            ugli_pkg::ST_Q_RD2:
                state_next = (mode_reg == ugli_pkg::MODE_LINEAR) ? ugli_pkg::ST_Q_RD3
                                                                 : ugli_pkg::ST_IDLE;
            ugli_pkg::ST_Q_RD3:
                state_next = ugli_pkg::ST_Q_X1;
            ugli_pkg::ST_Q_X1:
                if (mdu_done)
                    state_next = ugli_pkg::ST_Q_W;
            ugli_pkg::ST_Q_W:
                if (mdu_done)
                    state_next = ugli_pkg::ST_Q_Y;
            ugli_pkg::ST_Q_Y:
                if (mdu_done)
                    state_next = ugli_pkg::ST_IDLE;
            default:
                state_next = ugli_pkg::ST_IDLE;
        endcase
    end

    // datapath and sequencer outputs
    always_comb
    begin
        cnt_next    = cnt_reg;
        origin_next = origin_reg;
        lgx_next    = lgx_reg;
        lrx_next    = lrx_reg;
        y0_next     = y0_reg;
        e_next      = e_reg;
        acc_next    = acc_reg;
        inc_next    = inc_reg;
        bin_next    = bin_reg;
        y1_next     = y1_reg;
        y2_next     = y2_reg;
        neg_next    = neg_reg;
        value_next  = value_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        mem_we      = 1'b0;
        waddr       = IDX_W'(cnt_reg);
        wdata       = y_reg;
        raddr       = bin_reg;
        mdu_req     = '{start: 1'b0, op: ugli_pkg::OP_MUL};
        mdu_a       = '0;
        mdu_b       = '0;
        case (state_reg)
            ugli_pkg::ST_DECODE:
            begin
                raddr = IDX_W'(cnt_reg - 1'b1);
                case (mode_reg)
                    ugli_pkg::MODE_CLEAR:
                    begin
                        cnt_next    = '0;
                        origin_next = '0;
                        lgx_next    = '0;
                        lrx_next    = '0;
                        done_next   = 1'b1;
                        value_next  = '0;
                        status_next = ugli_pkg::STAT_OK;
                    end
                    ugli_pkg::MODE_APPEND:
                    begin
                        value_next  = '0;
                        status_next = ugli_pkg::STAT_OK;
                        if (first_pt)
                        begin
                            mem_we      = 1'b1;
                            waddr       = '0;
                            origin_next = x_reg;
                            lgx_next    = x_reg;
                            lrx_next    = x_reg;
                            cnt_next    = CNT_W'(1);
                            done_next   = 1'b1;
                        end
                        else if (not_asc)
                        begin
                            status_next = ugli_pkg::STAT_NOT_ASC;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            lrx_next  = x_reg;
                            done_next = app_skip;
                        end
                    end
                    default:
                    begin
                        value_next = '0;
                        if (q_oor)
                        begin
                            status_next = ugli_pkg::STAT_RANGE;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            status_next = ugli_pkg::STAT_OK;
                            mdu_req     = '{start: 1'b1, op: ugli_pkg::OP_MUL};
                            mdu_a       = A_W'({1'b0, off});
                            mdu_b       = B_W'(recip_reg);
                        end
                    end
                endcase
            end
            ugli_pkg::ST_A_RD:
            begin
                y0_next = rdata_reg;
                if (den_bad)
                    done_next = 1'b1;
                else
                begin
                    mdu_req = '{start: 1'b1, op: ugli_pkg::OP_DIV};
                    mdu_a   = (A_W'(y_reg) - A_W'(rdata_reg)) <<< FRAC_BITS;
                    mdu_b   = B_W'(den[31:0]);
                end
            end
            ugli_pkg::ST_A_DIV:
                if (mdu_done)
                begin
                    mdu_req = '{start: 1'b1, op: ugli_pkg::OP_MUL};
                    mdu_a   = mdu_p[A_W-1:0];
                    mdu_b   = B_W'(step_reg);
                end
            ugli_pkg::ST_A_MUL:
                if (mdu_done)
                begin
                    inc_next = mdu_p;
                    acc_next = mdu_p;
                    e_next   = E_W'(lgx_reg) + E_W'({1'b0, step_reg});
                end
            ugli_pkg::ST_A_LOOP:
            begin
                // write one grid entry per cycle while the grid x is below the point and the table has room
                wdata = sat32(SAT_W'(y0_reg) + SAT_W'(acc_reg >>> FRAC_BITS));
                if (!loop_go)
                    done_next = 1'b1;
                else if (loop_full)
                begin
                    status_next = ugli_pkg::STAT_FULL;
                    done_next   = 1'b1;
                end
                else
                begin
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    lgx_next = e_reg[31:0];
                    e_next   = e_reg + E_W'({1'b0, step_reg});
                    acc_next = acc_reg + inc_reg;
                end
            end
            ugli_pkg::ST_Q_BIN:
                if (mdu_done)
                    bin_next = IDX_W'(bin_fin);
            ugli_pkg::ST_Q_RD1:
                raddr = bin_reg;
            ugli_pkg::ST_Q_RD2:
            begin
                raddr   = IDX_W'(bin_reg + 1'b1);
                y1_next = rdata_reg;
                if (mode_reg != ugli_pkg::MODE_LINEAR)
                begin
                    value_next = rdata_reg;
                    done_next  = 1'b1;
                end
            end
            ugli_pkg::ST_Q_RD3:
            begin
                y2_next = rdata_reg;
                mdu_req = '{start: 1'b1, op: ugli_pkg::OP_MUL};
                mdu_a   = A_W'({1'b0, step_reg});
                mdu_b   = B_W'(bin_reg);
            end
            ugli_pkg::ST_Q_X1:
                if (mdu_done)
                begin
                    neg_next = dx[P_W];
                    mdu_req  = '{start: 1'b1, op: ugli_pkg::OP_MUL};
                    mdu_a    = A_W'({1'b0, mag});
                    mdu_b    = B_W'(recip_reg);
                end
            ugli_pkg::ST_Q_W:
                if (mdu_done)
                begin
                    mdu_req = '{start: 1'b1, op: ugli_pkg::OP_MUL};
                    mdu_a   = neg_reg ? A_W'(-dy) : A_W'(dy);
                    mdu_b   = B_W'(w_mag);
                end
            ugli_pkg::ST_Q_Y:
                if (mdu_done)
                begin
                    value_next = sat32(SAT_W'(y1_reg) + SAT_W'(mdu_p >>> FRAC_BITS));
                    done_next  = 1'b1;
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ugli_pkg::ST_IDLE;
            cnt_reg    <= '0;
            origin_reg <= '0;
            lgx_reg    <= '0;
            lrx_reg    <= '0;
            step_reg   <= '0;
            recip_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            origin_reg <= origin_next;
            lgx_reg    <= lgx_next;
            lrx_reg    <= lrx_next;
            done_reg   <= done_next;
            if (cfg_we && cfg_index == ugli_pkg::CFG_STEP)
                step_reg <= cfg_data;
            if (cfg_we && cfg_index == ugli_pkg::CFG_RECIP)
                recip_reg <= cfg_data;
        end
    end

    // hold the command beat and the working registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ugli_pkg::ST_IDLE && start)
        begin
            mode_reg <= mode;
            x_reg    <= abscissa;
            y_reg    <= ordinate;
        end
        y0_reg     <= y0_next;
        e_reg      <= e_next;
        acc_reg    <= acc_next;
        inc_reg    <= inc_next;
        bin_reg    <= bin_next;
        y1_reg     <= y1_next;
        y2_reg     <= y2_next;
        neg_reg    <= neg_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[waddr] <= wdata;
        rdata_reg <= grid_mem[raddr];
    end

    assign busy         = (state_reg != ugli_pkg::ST_IDLE);
    assign done         = done_reg;
    assign value        = value_reg;
    assign status       = status_reg;
    assign entries_used = 9'(cnt_reg);

endmodule

// ===== rtl/ugli_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugli_port_checks: port-level checks of the grid lookup interpolator
// Watches command and result beats and the entry count over time.
// ----------------------------------------------------------------------------
module ugli_port_checks #(
    parameter int TABLE_DEPTH = ugli_pkg::TABLE_DEPTH_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] value,
    input logic [1:0]         status,
    input logic [8:0]         entries_used
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command beat taken without going busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ugli_pkg::STAT_OK |-> value == '0)
        else $error("nonzero value on a failed command");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        entries_used <= 9'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !start |=> $stable(entries_used))
        else $error("entry count moved while idle");

endmodule

bind uniform_grid_lut_interpolator ugli_port_checks #(.TABLE_DEPTH(TABLE_DEPTH)) u_ugli_checker (.*);

// ===== bench/ugli_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugli_checker: result checker for the grid lookup interpolator
// Watches command, register and result beats, predicts every answer from its
// own copy of the table and registers, and counts mismatched fields and unexpected beats.
// ----------------------------------------------------------------------------
module ugli_checker
    import ugli_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         mode,
    input  logic signed [31:0] abscissa,
    input  logic signed [31:0] ordinate,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               done,
    input  logic signed [31:0] value,
    input  logic [1:0]         status,
    input  logic [8:0]         entries_used,
    output int                 errors,
    output int                 outstanding
);

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int FB    = FRAC_BITS_DEF;

    typedef struct {
        logic signed [31:0] val;
        logic [1:0]         stat;
        logic [8:0]         used;
    } answer_t;

    answer_t answer_q[$];

    int          grid_tbl [DEPTH];
    int          used_cnt;
    int          origin_x;
    int          last_grid;
    int          last_raw;
    logic [31:0] step_reg;
    logic [31:0] recip_reg;

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Add grid entries along the line from the last entry to the new point.
    function automatic logic [1:0] add_point(input longint x, input longint y);
        longint x0, y0, slope, den, gx, stp;
        logic [1:0] st;
        st = STAT_OK;
        stp = longint'(step_reg);
        if (used_cnt == 0)
        begin
            grid_tbl[0] = int'(y);
            origin_x = int'(x);
            last_grid = int'(x);
            last_raw = int'(x);
            used_cnt = 1;
            return STAT_OK;
        end
        if (x <= longint'(last_raw))
            return STAT_NOT_ASC;
        last_raw = int'(x);
        if (stp == 0 || used_cnt > DEPTH)
            return STAT_OK;
        x0 = last_grid;
        y0 = grid_tbl[used_cnt - 1];
        den = x - x0;
        if (den <= 0)
            return STAT_OK;
        slope = ((y - y0) * (64'sd1 <<< FB)) / den;
        gx = x0 + stp;
        while (gx < x)
        begin
            if (used_cnt >= DEPTH)
            begin
                st = STAT_FULL;
                break;
            end
            grid_tbl[used_cnt] = clip32(y0 + ((slope * (gx - x0)) >>> FB));
            used_cnt++;
            last_grid = int'(gx);
            gx += stp;
        end
        return st;
    endfunction

    function automatic logic [1:0] look_up(input longint x, input bit interp,
                                           output logic signed [31:0] v);
        logic [63:0] off, bin, mag, w;
        longint      x1, dx, wv, y1, y2;
        v = '0;
        if (step_reg == 0 || used_cnt < 2 || used_cnt > DEPTH ||
            x < longint'(origin_x) || x > longint'(last_grid))
            return STAT_RANGE;
        off = 64'(x - longint'(origin_x));
        bin = (off * {32'd0, recip_reg}) >> (2 * FB);
        if (bin >= 64'(used_cnt))
            bin = 64'(used_cnt - 1);
        if (!interp)
        begin
            v = grid_tbl[bin];
            return STAT_OK;
        end
        if (bin == 64'(used_cnt - 1))
            bin--;
        x1 = longint'(origin_x) + longint'(bin) * longint'(step_reg);
        dx = x - x1;
        mag = 64'(dx < 0 ? -dx : dx);
        if (mag > 64'd2147483647)
            mag = 64'd2147483647;
        w = (mag * {32'd0, recip_reg}) >> FB;
        if (w > (64'd1 << (FB + 4)))
            w = 64'd1 << (FB + 4);
        wv = (dx < 0) ? -longint'(w) : longint'(w);
        y1 = grid_tbl[bin];
        y2 = grid_tbl[bin + 1];
        v = clip32(y1 + (((y2 - y1) * wv) >>> FB));
        return STAT_OK;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t a, e;
        if (!rst_n)
        begin
            answer_q.delete();
            used_cnt = 0;
            origin_x = 0;
            last_grid = 0;
            last_raw = 0;
            step_reg = '0;
            recip_reg = '0;
            errors = 0;
            outstanding = 0;
        end
        else
        begin
            // compare a result beat with the oldest expected answer
            if (done)
            begin
                if (answer_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat value=%0d status=%0d used=%0d",
                             $time, value, status, entries_used);
                    errors++;
                end
                else
                begin
                    e = answer_q.pop_front();
                    if (value !== e.val)
                    begin
                        $display("%0t: value expected %0d actual %0d", $time, e.val, value);
                        errors++;
                    end
                    if (status !== e.stat)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.stat, status);
                        errors++;
                    end
                    if (entries_used !== e.used)
                    begin
                        $display("%0t: entries_used expected %0d actual %0d",
                                 $time, e.used, entries_used);
                        errors++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_STEP)
                    step_reg = cfg_data;
                else
                    recip_reg = cfg_data;
            end
            if (start && !busy)
            begin
                a.val = '0;
                a.stat = STAT_OK;
                case (mode)
                    MODE_CLEAR:
                    begin
                        used_cnt = 0;
                        origin_x = 0;
                        last_grid = 0;
                        last_raw = 0;
                    end
                    MODE_APPEND: a.stat = add_point(abscissa, ordinate);
                    MODE_NEAREST: a.stat = look_up(abscissa, 1'b0, a.val);
                    default: a.stat = look_up(abscissa, 1'b1, a.val);
                endcase
                a.used = 9'(used_cnt);
                answer_q.insert(answer_q.size(), a);
            end
            outstanding = answer_q.size();
        end
    end

endmodule

// ===== bench/uniform_grid_lut_interpolator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_grid_lut_interpolator_tb: stimulus and verdict for the interpolator
// Drives directed table builds and queries, then random tables built from
// mostly ascending points under several grid settings, with bursty command traffic.
// ----------------------------------------------------------------------------
module uniform_grid_lut_interpolator_tb;
    import ugli_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         mode;
    logic signed [31:0] abscissa;
    logic signed [31:0] ordinate;
    logic               cfg_we;
    logic               cfg_index;
    logic [31:0]        cfg_data;
    logic               done;
    logic signed [31:0] value;
    logic [1:0]         status;
    logic [8:0]         entries_used;
    int                 errors;
    int                 outstanding;

    int                 burst_left;
    int                 cmd_count;

    uniform_grid_lut_interpolator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .abscissa(abscissa), .ordinate(ordinate), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .value(value),
        .status(status), .entries_used(entries_used)
    );

    ugli_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .abscissa(abscissa), .ordinate(ordinate), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .value(value),
        .status(status), .entries_used(entries_used), .errors(errors),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run (about 900 commands plus
    // sender gaps).
    initial
    begin
        #40ms;
        $display("uniform_grid_lut_interpolator test failed");
        $finish;
    end

    // Issue one command beat. Inputs move on the falling edge; the beat is
    // taken on the rising edge where busy is low. Between bursts, drop start
    // for a random gap so idle cycles land on every phase of the work.
    task automatic issue_cmd(input logic [1:0] m, input logic signed [31:0] x,
                             input logic signed [31:0] y);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap > 0)
            begin
                start = 1'b0;
                repeat (gap) @(negedge clk);
            end
            // long stretches with no gaps now and then
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        start = 1'b1;
        mode = m;
        abscissa = x;
        ordinate = y;
        // busy only moves on rising edges, so its falling-edge value holds
        while (busy) @(negedge clk);
        @(posedge clk);
        burst_left--;
        cmd_count++;
    endtask

    // Hold until every expected answer is back and the block is quiet.
    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (outstanding != 0 || busy) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_grid(input logic [31:0] stp, input logic [31:0] rcp);
        wait_idle();
        write_reg(CFG_STEP, stp);
        write_reg(CFG_RECIP, rcp);
    endtask

    // Pick a grid setting: mostly consistent step/reciprocal pairs, with the
    // register extremes and mismatched pairs mixed in.
    task automatic pick_grid();
        logic [31:0] stp;
        case ($urandom_range(0, 9))
            0: set_grid(32'd0, 32'd0);
            1: set_grid(32'hffffffff, 32'hffffffff);
            2: set_grid(32'd1, 32'hffffffff);
            3: set_grid($urandom_range(32'h100, 32'h100000), $urandom);
            4: set_grid(32'h8000, 32'h20000);
            5: set_grid(32'h10000, 32'h10000);
            default:
            begin
                stp = $urandom_range(32'h1000, 32'h100000);
                set_grid(stp, 32'((64'd1 << 32) / stp));
            end
        endcase
    endtask

    // One table: a clear most of the time, ascending points with random content, then queries
    // spread over the table span, with some noise and broken ordering.
    task automatic build_and_query();
        longint x, xfirst, xlast, span, qx;
        int     npts, nq;
        if ($urandom_range(0, 2) != 0)
            issue_cmd(MODE_CLEAR, $urandom, $urandom);
        x = ($urandom_range(0, 3) == 0) ? longint'(int'($urandom))
                                        : longint'($urandom_range(0, 32'h100000)) - 32'h80000;
        xfirst = x;
        xlast = x;
        npts = $urandom_range(2, 10);
        for (int i = 0; i < npts; i++)
        begin
            case ($urandom_range(0, 9))
                0: x = xlast - $urandom_range(0, 32'h10000);    // out of order
                1: x = xlast + $urandom_range(1, 32'h800);
                2: x = xlast + $urandom_range(1, 32'h8000000);
                default: x = xlast + $urandom_range(1, 32'h80000);
            endcase
            if (x > 64'sd2147483647)
                x = 64'sd2147483647;
            if (x > xlast)
                xlast = x;
            issue_cmd(MODE_APPEND, x[31:0],
                      ($urandom_range(0, 4) == 0) ? $urandom
                                                  : $urandom_range(0, 32'h400000) - 32'h200000);
        end
        nq = $urandom_range(3, 14);
        span = xlast - xfirst;
        if (span > 64'h0ffffffff)
            span = 64'h0ffffffff;
        for (int i = 0; i < nq; i++)
        begin
            qx = xfirst + $urandom_range(0, 32'(span));
            if ($urandom_range(0, 7) == 0)
                qx = longint'(int'($urandom));
            if (qx > 64'sd2147483647)
                qx = 64'sd2147483647;
            issue_cmd($urandom_range(0, 1) ? MODE_LINEAR : MODE_NEAREST, qx[31:0], $urandom);
        end
        if ($urandom_range(0, 5) == 0)
            issue_cmd(2'($urandom_range(0, 3)), $urandom, $urandom);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_CLEAR;
        abscissa = '0;
        ordinate = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_STEP;
        cfg_data = '0;
        burst_left = 0;
        cmd_count = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: queries on an empty table, zero step append, then a table
        // at step 1.0 with extreme coordinates, every query edge and a fill-up.
        issue_cmd(MODE_LINEAR, 32'sd0, 32'sd0);
        issue_cmd(MODE_APPEND, 32'sd0, 32'sd100);
        issue_cmd(MODE_APPEND, 32'sh00050000, 32'sd200);   // step still zero
        issue_cmd(MODE_NEAREST, 32'sd0, 32'sd0);
        set_grid(32'h10000, 32'h10000);
        issue_cmd(MODE_CLEAR, 32'sd0, 32'sd0);
        issue_cmd(MODE_APPEND, 32'sh80000000, 32'sh7fffffff);
        issue_cmd(MODE_NEAREST, 32'sh80000000, 32'sd0);     // one entry only
        issue_cmd(MODE_APPEND, 32'sh80040000, 32'sh80000000);
        issue_cmd(MODE_APPEND, 32'sh80040000, 32'sd0);      // equal x
        issue_cmd(MODE_APPEND, 32'sh80000000, 32'sd0);      // below last x
        issue_cmd(MODE_NEAREST, 32'sh80000000, 32'sd0);
        issue_cmd(MODE_LINEAR, 32'sh80018000, 32'sd0);
        issue_cmd(MODE_LINEAR, 32'sh80030000, 32'sd0);      // last grid x
        issue_cmd(MODE_LINEAR, 32'sh80040000, 32'sd0);      // past last grid x
        issue_cmd(MODE_APPEND, 32'sh7fffffff, 32'sh7fffffff); // overflows table
        issue_cmd(MODE_NEAREST, 32'sh80ffffff, 32'sd0);
        issue_cmd(MODE_LINEAR, 32'sh80ff0000, 32'sd0);
        issue_cmd(MODE_LINEAR, 32'sh7fffffff, 32'sd0);
        issue_cmd(MODE_APPEND, 32'sh7fffffff, 32'sd5);      // full and not ascending
        set_grid(32'h10000, 32'hffffffff);                  // oversized reciprocal
        issue_cmd(MODE_LINEAR, 32'sh80800000, 32'sd0);
        issue_cmd(MODE_CLEAR, 32'sh7fffffff, 32'sh7fffffff);
        issue_cmd(MODE_LINEAR, 32'sd0, 32'sd0);

        // Random tables under a mix of grid settings.
        while (cmd_count < 900)
        begin
            if ($urandom_range(0, 3) == 0)
                pick_grid();
            build_and_query();
        end

        wait_idle();
        repeat (400) @(negedge clk);
        if (errors == 0)
            $display("uniform_grid_lut_interpolator test passed");
        else
            $display("uniform_grid_lut_interpolator test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ugli_pkg.sv
rtl/ugli_mdu.sv
rtl/uniform_grid_lut_interpolator.sv
rtl/ugli_checker.sv
bench/ugli_checker.sv
bench/uniform_grid_lut_interpolator_tb.sv
